>>> rtl/lapc_pkg.sv
// Shared types and constants for the lock actuator and pattern controller.
`default_nettype none
package lapc_pkg;

	// request codes carried on req_type
	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_UNLOCK = 3'd1,
		REQ_LOCK   = 3'd2,
		REQ_BEEP   = 3'd3,
		REQ_LED    = 3'd4
	} req_t;

	// led mode codes carried on cmd_value
	localparam logic signed [7:0] LED_MODE_OFF   = 8'sd0;
	localparam logic signed [7:0] LED_MODE_ON    = 8'sd1;
	localparam logic signed [7:0] LED_MODE_SLOW  = 8'sd2;
	localparam logic signed [7:0] LED_MODE_FAST  = 8'sd3;

	localparam int unsigned ELAPSED_W = 17;
	localparam int unsigned PHASE_W   = 9;
	localparam int unsigned COUNT_W   = 8;

	localparam logic [ELAPSED_W-1:0] MS_PER_SEC  = 17'd1000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	// pattern timing in ms and pulse counts
	localparam logic [PHASE_W-1:0] CHIRP_ON_MS    = 9'd50;
	localparam logic [PHASE_W-1:0] BEEP_SHORT_MS  = 9'd100;
	localparam logic [PHASE_W-1:0] BEEP_LONG_ON   = 9'd300;
	localparam logic [PHASE_W-1:0] BEEP_LONG_OFF  = 9'd200;
	localparam logic [PHASE_W-1:0] BLINK_SLOW_MS  = 9'd200;
	localparam logic [PHASE_W-1:0] BLINK_FAST_MS  = 9'd100;
	localparam logic [COUNT_W-1:0] BLINK_SLOW_CNT = 8'd3;
	localparam logic [COUNT_W-1:0] BLINK_FAST_CNT = 8'd5;

	// control from the request decoder to the pattern engine
	typedef struct packed {
		logic               step;
		logic               tick;
		logic               start;
		logic               on_led;
		logic [COUNT_W-1:0] count;
		logic [PHASE_W-1:0] on_ms;
		logic [PHASE_W-1:0] off_ms;
		logic               led_wr;
		logic               led_val;
	} pat_ctrl_t;

	// status from the pattern engine: current busy and levels after this step
	typedef struct packed {
		logic busy;
		logic active_nxt;
		logic buzzer_nxt;
		logic led_nxt;
	} pat_stat_t;

endpackage
`default_nettype wire

>>> rtl/lapc_pattern.sv
// Beep and blink pattern engine with buzzer and led level registers.
`default_nettype none
module lapc_pattern (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lapc_pkg::pat_ctrl_t  ctrl,
	output      lapc_pkg::pat_stat_t  stat
);
	import lapc_pkg::*;

	logic               act_q, on_led_q, high_q, buzz_q, led_q;
	logic [PHASE_W-1:0] ph_q, on_q, off_q;
	logic [COUNT_W-1:0] pl_q;

	logic               act_n, on_led_n, high_n, buzz_n, led_n;
	logic [PHASE_W-1:0] ph_n, on_n, off_n;
	logic [COUNT_W-1:0] pl_n;

	// work out the pattern state after the word in flight
	always_comb begin
		act_n    = act_q;
		on_led_n = on_led_q;
		high_n   = high_q;
		buzz_n   = buzz_q;
		led_n    = led_q;
		ph_n     = ph_q;
		on_n     = on_q;
		off_n    = off_q;
		pl_n     = pl_q;
		if (ctrl.tick && act_q) begin
			// count down one ms of the current phase
			ph_n = ph_q - PHASE_W'(ph_q != '0);
			if (ph_n == '0) begin
				if (high_q) begin
					if (on_led_q) led_n = 1'b0;
					else buzz_n = 1'b0;
					high_n = 1'b0;
				end
				if (high_q && off_q != '0) begin
					ph_n = off_q;
				end else begin
					// close the pulse and start the next one, or end the pattern after the last
					pl_n = pl_q - COUNT_W'(pl_q != '0);
					if (pl_n == '0) begin
						act_n  = 1'b0;
						high_n = 1'b0;
						ph_n   = '0;
					end else begin
						high_n = 1'b1;
						ph_n   = on_q;
						if (on_led_q) led_n = 1'b1;
						else buzz_n = 1'b1;
					end
				end
			end
		end else if (ctrl.start) begin
			act_n    = 1'b1;
			on_led_n = ctrl.on_led;
			pl_n     = ctrl.count;
			on_n     = ctrl.on_ms;
			off_n    = ctrl.off_ms;
			high_n   = 1'b1;
			ph_n     = ctrl.on_ms;
			if (ctrl.on_led) led_n = 1'b1;
			else buzz_n = 1'b1;
		end else if (ctrl.led_wr) begin
			led_n = ctrl.led_val;
		end
	end

	// commit the state when the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			on_led_q <= 1'b0;
			high_q   <= 1'b0;
			buzz_q   <= 1'b0;
			led_q    <= 1'b0;
			ph_q     <= '0;
			on_q     <= '0;
			off_q    <= '0;
			pl_q     <= '0;
		end else if (ctrl.step) begin
			act_q    <= act_n;
			on_led_q <= on_led_n;
			high_q   <= high_n;
			buzz_q   <= buzz_n;
			led_q    <= led_n;
			ph_q     <= ph_n;
			on_q     <= on_n;
			off_q    <= off_n;
			pl_q     <= pl_n;
		end
	end

	assign stat.busy       = act_q;
	assign stat.active_nxt = act_n;
	assign stat.buzzer_nxt = buzz_n;
	assign stat.led_nxt    = led_n;

`ifndef SYNTHESIS
	a_active_has_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (pl_q != '0 && ph_q != '0))
		else $error("pattern active with no pulse or phase time left");
	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && act_q && !act_n) |-> (on_led_q ? !led_n : !buzz_n))
		else $error("pattern ended with its line high");
`endif
endmodule
`default_nettype wire

>>> rtl/lock_actuator_pattern_controller.sv
// Lock actuator and pattern controller: relay timeout, request decode, output register.
// A word accepted into the input register passes through decode into the result register.
// Throughput: one word per cycle while the receiver does not stall; an input register
// feeds one pass of decode, counter and compare logic, which loads the result register.
// The input stalls only while both registers hold words and the receiver stalls.
// Reset (arst_n low) locks the relay, stops any pattern and empties both registers.
`default_nettype none
module lock_actuator_pattern_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [2:0]        req_type,
	input  wire logic signed [7:0] cmd_value,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic              relay_out,
	output      logic              buzzer_out,
	output      logic              led_out,
	output      logic              accepted,
	output      logic              busy_res,
	output      logic              auto_locked
);
	import lapc_pkg::*;

	logic                     vld_s1;
	logic [2:0]               req_s1;
	logic signed [7:0]        val_s1;
	logic                     fire;

	logic                     relay_q, tmo_q;
	logic [ELAPSED_W-1:0]     elapsed_q, limit_q;
	logic                     relay_n, tmo_n, acc_n, relock_n;
	logic [ELAPSED_W-1:0]     elapsed_n, limit_n;

	pat_ctrl_t                pctl;
	pat_stat_t                pst;

	// move a word on when the result register is free or being emptied
	assign fire     = vld_s1 && (!out_valid || !out_stall);
	assign in_stall = vld_s1 && !fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= req_type;
			val_s1 <= cmd_value;
		end
	end

	// decode the word and update the relay timer
	always_comb begin
		relay_n   = relay_q;
		tmo_n     = tmo_q;
		elapsed_n = elapsed_q;
		limit_n   = limit_q;
		acc_n     = 1'b1;
		relock_n  = 1'b0;
		pctl      = '0;
		pctl.step = fire;
		if (req_s1 == REQ_TICK) begin
			pctl.tick = 1'b1;
			if (relay_q && tmo_q && elapsed_q != ELAPSED_MAX) begin
				elapsed_n = elapsed_q + ELAPSED_W'(1);
			end
		end else if (pst.busy) begin
			acc_n = 1'b0;
		end else begin
			case (req_s1)
				REQ_UNLOCK: begin
					relay_n   = 1'b1;
					elapsed_n = '0;
					tmo_n     = !val_s1[7];
					limit_n   = val_s1[7] ? '0 : ELAPSED_W'(val_s1[6:0]) * MS_PER_SEC;
				end
				REQ_LOCK: begin
					relay_n = 1'b0;
					tmo_n   = 1'b0;
				end
				REQ_BEEP: begin
					pctl.start = 1'b1;
					if (val_s1 == 8'sd0) begin
						pctl.count = COUNT_W'(1);
						pctl.on_ms = CHIRP_ON_MS;
					end else if (!val_s1[7]) begin
						pctl.count  = val_s1;
						pctl.on_ms  = BEEP_SHORT_MS;
						pctl.off_ms = BEEP_SHORT_MS;
					end else begin
						pctl.count  = COUNT_W'(-val_s1);
						pctl.on_ms  = BEEP_LONG_ON;
						pctl.off_ms = BEEP_LONG_OFF;
					end
				end
				REQ_LED: begin
					if (val_s1 == LED_MODE_OFF || val_s1 == LED_MODE_ON) begin
						pctl.led_wr  = 1'b1;
						pctl.led_val = val_s1[0];
					end else if (val_s1 == LED_MODE_SLOW) begin
						pctl.start  = 1'b1;
						pctl.on_led = 1'b1;
						pctl.count  = BLINK_SLOW_CNT;
						pctl.on_ms  = BLINK_SLOW_MS;
						pctl.off_ms = BLINK_SLOW_MS;
					end else if (val_s1 == LED_MODE_FAST) begin
						pctl.start  = 1'b1;
						pctl.on_led = 1'b1;
						pctl.count  = BLINK_FAST_CNT;
						pctl.on_ms  = BLINK_FAST_MS;
						pctl.off_ms = BLINK_FAST_MS;
					end
				end
				default: begin
				end
			endcase
		end
		// relock once the timeout has run out and no pattern plays
		if (!pst.active_nxt && relay_n && tmo_n && elapsed_n > limit_n) begin
			relay_n  = 1'b0;
			tmo_n    = 1'b0;
			relock_n = 1'b1;
		end
	end

	lapc_pattern u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctl),
		.stat   (pst)
	);

	// relay timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q   <= 1'b0;
			tmo_q     <= 1'b0;
			elapsed_q <= '0;
			limit_q   <= '0;
		end else if (fire) begin
			relay_q   <= relay_n;
			tmo_q     <= tmo_n;
			elapsed_q <= elapsed_n;
			limit_q   <= limit_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			relay_out   <= relay_n;
			buzzer_out  <= pst.buzzer_nxt;
			led_out     <= pst.led_nxt;
			accepted    <= acc_n;
			busy_res    <= pst.active_nxt;
			auto_locked <= relock_n;
		end
	end

`ifndef SYNTHESIS
	a_reject_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> busy_res)
		else $error("word rejected with no pattern playing");
	a_relock_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && auto_locked) |-> (!relay_out && !busy_res))
		else $error("relock reported with relay open or pattern playing");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_valid && out_stall))
		else $error("input stalled while the pipeline can move");
	a_timer_off_locked: assert property (@(posedge clk) disable iff (!arst_n)
		tmo_q |-> relay_q)
		else $error("relock timer armed with the relay locked");
`endif
endmodule
`default_nettype wire
